// File: src/ordered_value_table_filter_assert.svh
// Assertion macros used by the checker file of the ordered value table filter.
// Every macro samples on the rising edge of clk and is switched off during reset.
`ifndef ORDERED_VALUE_TABLE_FILTER_ASSERT_SVH
`define ORDERED_VALUE_TABLE_FILTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OVTF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define OVTF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/ovtf_pkg.sv
// ----------------------------------------------------------------------------
// ovtf_pkg
// Shared types and constants of the ordered value table filter.
// ----------------------------------------------------------------------------
package ovtf_pkg;

	localparam int OP_W    = 3;
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 5;

	localparam logic [OP_W-1:0] OP_INSERT      = 3'd0;
	localparam logic [OP_W-1:0] OP_LOOKUP      = 3'd1;
	localparam logic [OP_W-1:0] OP_REM_LESS    = 3'd2;
	localparam logic [OP_W-1:0] OP_REM_EQUAL   = 3'd3;
	localparam logic [OP_W-1:0] OP_REM_GREATER = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} ovtf_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic start;   // take the offered item
		logic issue;   // read the next stored entry
		logic commit;  // settle the count and load the result register
	} ovtf_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic in_is_scan;  // offered item has to walk the table
		logic more_reads;  // entries remain to be read
		logic busy_s1;     // a read is still in flight
	} ovtf_status_t;

	function automatic logic is_remove_op(logic [OP_W-1:0] op);
		logic r;
		unique case (op)
			OP_REM_LESS, OP_REM_EQUAL, OP_REM_GREATER: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic is_scan_op(logic [OP_W-1:0] op);
		return is_remove_op(op) || (op == OP_LOOKUP);
	endfunction

endpackage

// File: src/ordered_value_table_filter.sv
// ----------------------------------------------------------------------------
// ordered_value_table_filter
// Ordered table of signed values with insert, lookup and filtered removal.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake              Payload
//  -------  ---------------------  -----------------------------------------
//  input    in_valid / in_ready    operation, value
//  output   out_valid / out_ready  found, count, is_empty, removed_count,
//                                  dropped
//
// An insert or an unknown operation goes from acceptance to the finish state,
// which loads the result register. A lookup or a removal walks the single read
// port of the entry memory one entry per cycle and waits in the scan state
// until the last read has settled before it moves on to hand-off.
// After a result is loaded the block is ready again in the next cycle, even
// while that result still waits in the output register; the next item only
// stalls at its own hand-off if the previous result has not been taken.
// Reset clears the entry count; the entry memory needs no clearing.
//
// The table is kept oldest-first in memory, so the newest entry sits at the
// top and an insert is one write. Removal walks the entries in order and
// writes each survivor back at a keep pointer that never passes the read
// pointer, which compacts the table in place and keeps the order intact.
// ----------------------------------------------------------------------------
module ordered_value_table_filter
	import ovtf_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [OP_W-1:0]           operation,
	input  logic signed [VALUE_W-1:0] value,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      found,
	output logic [COUNT_W-1:0]        count,
	output logic                      is_empty,
	output logic [COUNT_W-1:0]        removed_count,
	output logic                      dropped
);

	ovtf_cmd_t    cmd;
	ovtf_status_t status;

	// The controller decides when an item is taken, when entries are read
	// and when the result is handed to the output register.
	ovtf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// The datapath owns the entries, the count and the result register.
	ovtf_dp #(
		.CAPACITY(CAPACITY)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.operation     (operation),
		.value         (value),
		.found         (found),
		.count         (count),
		.is_empty      (is_empty),
		.removed_count (removed_count),
		.dropped       (dropped)
	);

endmodule

// File: src/ovtf_ram.sv
// ----------------------------------------------------------------------------
// ovtf_ram
// Generic RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module ovtf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                         wr_data,
	input  logic                                     rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: src/ovtf_ctrl.sv
// ----------------------------------------------------------------------------
// ovtf_ctrl
// Controller: sequences accept, table walk and result hand-off.
// ----------------------------------------------------------------------------
module ovtf_ctrl
	import ovtf_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  logic         out_ready,
	input  ovtf_status_t status,
	output ovtf_cmd_t    cmd
);

	ovtf_state_t state_q, state_next;
	logic        out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_next = state_q;
		cmd        = '0;
		in_ready   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.start  = 1'b1;
					state_next = status.in_is_scan ? ST_SCAN : ST_FINISH;
				end
			end
			ST_SCAN: begin
				cmd.issue = status.more_reads;
				if (!status.more_reads && !status.busy_s1) begin
					state_next = ST_FINISH;
				end
			end
			ST_FINISH: begin
				// The result register is free or empties in this cycle.
				if (!out_valid_q || out_ready) begin
					cmd.commit = 1'b1;
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// File: src/ovtf_dp.sv
// ----------------------------------------------------------------------------
// ovtf_dp
// Datapath: entry memory, walk counters, compare and result register.
// ----------------------------------------------------------------------------
module ovtf_dp
	import ovtf_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ovtf_cmd_t                 cmd,
	output ovtf_status_t              status,
	input  logic [OP_W-1:0]           operation,
	input  logic signed [VALUE_W-1:0] value,
	output logic                      found,
	output logic [COUNT_W-1:0]        count,
	output logic                      is_empty,
	output logic [COUNT_W-1:0]        removed_count,
	output logic                      dropped
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	// The memory holds the oldest entry at address 0 and the newest at
	// address cnt_q - 1, so an insert is a single write at the top.
	logic [CW-1:0]             cnt_q;
	logic [CW-1:0]             rd_idx_q;
	logic                      rd_vld_s1;
	logic [CW-1:0]             keep_q;
	logic [CW-1:0]             removed_q;
	logic                      found_q;
	logic                      dropped_q;
	logic [OP_W-1:0]           op_q;
	logic signed [VALUE_W-1:0] value_q;

	logic                      res_found_q;
	logic [COUNT_W-1:0]        res_count_q;
	logic                      res_empty_q;
	logic [COUNT_W-1:0]        res_removed_q;
	logic                      res_dropped_q;

	logic                      wr_en;
	logic [AW-1:0]             wr_addr;
	logic [VALUE_W-1:0]        wr_data;
	logic [VALUE_W-1:0]        rd_data;
	logic signed [VALUE_W-1:0] held;
	logic                      hit;
	logic                      drop_it;
	logic                      ins_ok;
	logic [CW-1:0]             new_cnt;

	ovtf_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (cmd.issue),
		.rd_addr (rd_idx_q[AW-1:0]),
		.rd_data (rd_data)
	);

	assign held = $signed(rd_data);
	assign hit  = (held == value_q);

	always_comb begin
		case (op_q)
			OP_REM_LESS:    drop_it = (held < value_q);
			OP_REM_EQUAL:   drop_it = hit;
			OP_REM_GREATER: drop_it = (held > value_q);
			default:        drop_it = 1'b0;
		endcase
	end

	assign ins_ok  = cmd.start && (operation == OP_INSERT) && (cnt_q != CAP_C);
	assign wr_en   = ins_ok || (rd_vld_s1 && is_remove_op(op_q) && !drop_it);
	assign wr_addr = cmd.start ? cnt_q[AW-1:0] : keep_q[AW-1:0];
	assign wr_data = cmd.start ? value : rd_data;
	assign new_cnt = is_remove_op(op_q) ? keep_q : cnt_q;

	assign status.in_is_scan = is_scan_op(operation);
	assign status.more_reads = (rd_idx_q != cnt_q);
	assign status.busy_s1    = rd_vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			rd_idx_q  <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.issue;
			if (cmd.start) begin
				rd_idx_q <= '0;
			end else if (cmd.issue) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			if (ins_ok) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (cmd.commit) begin
				cnt_q <= new_cnt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q      <= operation;
			value_q   <= value;
			keep_q    <= '0;
			removed_q <= '0;
			found_q   <= 1'b0;
			dropped_q <= (operation == OP_INSERT) && (cnt_q == CAP_C);
		end else if (rd_vld_s1) begin
			if (op_q == OP_LOOKUP) begin
				found_q <= found_q | hit;
			end else if (is_remove_op(op_q)) begin
				if (drop_it) begin
					removed_q <= removed_q + 1'b1;
				end else begin
					keep_q <= keep_q + 1'b1;
				end
			end
		end
		if (cmd.commit) begin
			res_found_q   <= found_q;
			res_count_q   <= COUNT_W'(new_cnt);
			res_empty_q   <= (new_cnt == '0);
			res_removed_q <= COUNT_W'(removed_q);
			res_dropped_q <= dropped_q;
		end
	end

	assign found         = res_found_q;
	assign count         = res_count_q;
	assign is_empty      = res_empty_q;
	assign removed_count = res_removed_q;
	assign dropped       = res_dropped_q;

endmodule

// File: src/ovtf_checker.sv
// ----------------------------------------------------------------------------
// ovtf_checker
// Port-level checks on the results of the ordered value table filter.
// ----------------------------------------------------------------------------
`include "ordered_value_table_filter_assert.svh"

module ovtf_checker
	import ovtf_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic               found,
	input logic [COUNT_W-1:0] count,
	input logic               is_empty,
	input logic [COUNT_W-1:0] removed_count,
	input logic               dropped
);

	`OVTF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(count) && $stable(found) && $stable(removed_count) && $stable(dropped), "result changed while stalled")
	`OVTF_ASSERT_NOW(a_empty_flag, out_valid, is_empty == (count == '0), "empty flag disagrees with count")
	`OVTF_ASSERT_NOW(a_one_kind, out_valid, !(found && dropped) && !(found && (removed_count != '0)) && !(dropped && (removed_count != '0)), "result mixes flags of different operations")
	`OVTF_ASSERT_NOW(a_drop_full, out_valid && dropped, count == COUNT_W'(CAPACITY), "insert dropped while table not full")

endmodule

bind ordered_value_table_filter ovtf_checker #(
	.CAPACITY(CAPACITY)
) u_ovtf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.found         (found),
	.count         (count),
	.is_empty      (is_empty),
	.removed_count (removed_count),
	.dropped       (dropped)
);
